// ----- hw/rtl/gsp_pkg.sv -----
// Shared types and constants for the step-limited grid path search.
// No dependencies.
package gsp_pkg;
  localparam int GridW = 8;
  localparam int GridH = 8;
  localparam int MaxResults = 64;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_LIST = 2'd1;
  localparam logic [1:0] OP_PATH = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;
endpackage

// ----- hw/rtl/grid_step_limited_path_search.sv -----
// Top level of the step-limited grid path search: configuration and core.
// Depends on gsp_pkg and gsp_core.
//
// A set command is taken while idle and busy does not rise. A list or path
// command keeps busy high while a single neighbor-check sequencer runs a
// breadth-first search, expanding the neighbors of each dequeued cell that
// lies below the step budget. A list then scans the grid once per distance
// level, until the budget is passed or 64 cells are found; a path checks the
// neighbors of each path cell in turn for a step one closer to the goal. The
// last beat carries out_last and appears in the cycle busy falls; results
// appear on single strobe cycles and cannot be held off by the receiver.
module grid_step_limited_path_search import gsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [2:0] cell_x,
  input  logic [2:0] cell_y,
  input  logic       passable,
  input  logic [2:0] goal_x,
  input  logic [2:0] goal_y,
  input  logic [5:0] max_steps,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data,
  output logic       strobe,
  output logic [2:0] out_x,
  output logic [2:0] out_y,
  output logic       out_valid,
  output logic       out_last
);
  logic [3:0] active_width, active_height, eff_w, eff_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width <= 4'd8;
      active_height <= 4'd8;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) active_width <= cfg_data;
      else active_height <= cfg_data;
    end
  end

  assign eff_w = (active_width > 4'(GridW)) ? 4'(GridW) : active_width;
  assign eff_h = (active_height > 4'(GridH)) ? 4'(GridH) : active_height;

  gsp_core u_core (
    .clk, .rst, .start, .busy, .opcode, .cell_x, .cell_y, .passable,
    .goal_x, .goal_y, .max_steps, .eff_w, .eff_h,
    .strobe, .out_x, .out_y, .out_valid, .out_last
  );
endmodule

// ----- hw/rtl/gsp_core.sv -----
// Sequencer and storage for the search: map, distances, queue and output.
// Depends on gsp_pkg.
module gsp_core import gsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [2:0] cell_x,
  input  logic [2:0] cell_y,
  input  logic       passable,
  input  logic [2:0] goal_x,
  input  logic [2:0] goal_y,
  input  logic [5:0] max_steps,
  input  logic [3:0] eff_w,
  input  logic [3:0] eff_h,
  output logic       strobe,
  output logic [2:0] out_x,
  output logic [2:0] out_y,
  output logic       out_valid,
  output logic       out_last
);
  localparam int XW = $clog2(GridW);
  localparam int YW = $clog2(GridH);
  localparam int CW = XW + YW;
  localparam int CELLS = GridW * GridH;
  localparam int PW = CW + 1;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_POP  = 11'b00000000010,
    S_RDQ  = 11'b00000000100,
    S_RDD  = 11'b00000001000,
    S_NBR  = 11'b00000010000,
    S_SCAN = 11'b00000100000,
    S_SCMP = 11'b00001000000,
    S_PDS  = 11'b00010000000,
    S_PATH = 11'b00100000000,
    S_PCMP = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

  state_t state;
  logic [CELLS-1:0] blocked;
  logic [CELLS-1:0] reached;
  logic [6:0] dist_mem [CELLS];
  logic [CW-1:0] queue [CELLS];
  logic [PW-1:0] head, tail;
  logic is_list;
  logic [5:0] limit;
  logic [CW-1:0] f1, f2;
  logic [XW-1:0] cx, sx, hx;
  logic [YW-1:0] cy, sy, hy;
  logic [6:0] cd;
  logic [1:0] dir;
  logic [6:0] scan_d;
  logic [CW-1:0] scan_c;
  logic [6:0] count;
  logic [CW-1:0] qrd;
  logic have;
  logic [CW-1:0] dra;
  logic [6:0] drd;
  logic hit, step_ok;

  logic [XW:0] nx;
  logic [YW:0] ny;
  logic nok;
  logic [CW-1:0] ncell;

  always_comb begin
    nx = {1'b0, cx};
    ny = {1'b0, cy};
    nok = 1'b0;
    case (dir)
      DIR_LEFT: begin
        nok = (cx != '0);
        nx = {1'b0, cx} - 1'b1;
      end
      DIR_RIGHT: begin
        nx = {1'b0, cx} + 1'b1;
        nok = (32'(nx) < 32'(eff_w));
      end
      DIR_DOWN: begin
        ny = {1'b0, cy} + 1'b1;
        nok = (32'(ny) < 32'(eff_h));
      end
      DIR_UP: begin
        nok = (cy != '0);
        ny = {1'b0, cy} - 1'b1;
      end
      default: nok = 1'b0;
    endcase
    ncell = {ny[YW-1:0], nx[XW-1:0]};
  end

  logic [XW-1:0] scx;
  logic [YW-1:0] scy;
  assign scx = scan_c[XW-1:0];
  assign scy = scan_c[CW-1:XW];
  assign busy = (state != S_IDLE);

  logic [XW-1:0] ix, gx;
  logic [YW-1:0] iy, gy;
  logic s_ok, g_ok;
  logic [CW-1:0] src;
  assign ix = XW'(cell_x);
  assign iy = YW'(cell_y);
  assign gx = XW'(goal_x);
  assign gy = YW'(goal_y);
  assign s_ok = (32'(cell_x) < 32'(eff_w)) && (32'(cell_y) < 32'(eff_h));
  assign g_ok = (32'(goal_x) < 32'(eff_w)) && (32'(goal_y) < 32'(eff_h));
  assign src = (opcode == OP_LIST) ? {iy, ix} : {gy, gx};

  always_comb begin
    case (state)
      S_RDQ: dra = qrd;
      S_SCAN: dra = scan_c;
      S_PATH: dra = ncell;
      default: dra = {sy, sx};
    endcase
  end

  always_ff @(posedge clk) begin
    drd <= dist_mem[dra];
  end

  assign hit = (32'(scx) < 32'(eff_w)) && (32'(scy) < 32'(eff_h)) &&
               reached[scan_c] && (drd == scan_d);
  assign step_ok = nok && reached[ncell] && (drd == cd - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == S_SCMP && hit && have) || (state == S_PCMP && step_ok) ||
                (state == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      blocked <= '0;
      reached <= '0;
      head <= '0;
      tail <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (opcode == OP_SET) begin
              if (s_ok) blocked[{iy, ix}] <= ~passable;
            end else if (opcode == OP_LIST || opcode == OP_PATH) begin
              is_list <= (opcode == OP_LIST);
              limit <= max_steps;
              sx <= ix;
              sy <= iy;
              count <= '0;
              have <= 1'b0;
              f1 <= {iy, ix};
              f2 <= src;
              if (max_steps == '0 || !s_ok || (opcode == OP_PATH && !g_ok)) begin
                state <= S_DONE;
              end else begin
                reached <= CELLS'(1) << src;
                dist_mem[src] <= '0;
                queue[0] <= src;
                head <= '0;
                tail <= PW'(1);
                state <= S_POP;
              end
            end
          end
        end
        S_POP: begin
          if (head < tail) begin
            qrd <= queue[head[CW-1:0]];
            head <= head + 1'b1;
            state <= S_RDQ;
          end else if (is_list) begin
            scan_d <= '0;
            scan_c <= '0;
            state <= S_SCAN;
          end else if (!reached[{sy, sx}]) begin
            state <= S_DONE;
          end else begin
            cx <= sx;
            cy <= sy;
            hx <= sx;
            hy <= sy;
            have <= 1'b1;
            count <= 7'd1;
            state <= S_PDS;
          end
        end
        S_RDQ: begin
          cx <= qrd[XW-1:0];
          cy <= qrd[CW-1:XW];
          dir <= DIR_LEFT;
          state <= S_RDD;
        end
        S_RDD: begin
          cd <= drd;
          state <= (drd >= {1'b0, limit}) ? S_POP : S_NBR;
        end
        S_NBR: begin
          if (nok && !reached[ncell] &&
              (!blocked[ncell] || ncell == f1 || ncell == f2) &&
              32'(tail) < CELLS) begin
            reached[ncell] <= 1'b1;
            dist_mem[ncell] <= cd + 7'd1;
            queue[tail[CW-1:0]] <= ncell;
            tail <= tail + 1'b1;
          end
          dir <= dir + 2'd1;
          if (dir == DIR_UP) state <= S_POP;
        end
        S_SCAN: begin
          if (scan_d > {1'b0, limit} || count == 7'(MaxResults)) begin
            state <= S_DONE;
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          // The newest cell is held back so that the final beat can carry out_last.
          if (hit) begin
            if (have) begin
              out_x <= 3'(hx);
              out_y <= 3'(hy);
              out_valid <= 1'b1;
              out_last <= 1'b0;
            end
            hx <= scx;
            hy <= scy;
            have <= 1'b1;
            count <= count + 7'd1;
          end
          if (scan_c == CW'(CELLS - 1)) begin
            scan_c <= '0;
            scan_d <= scan_d + 7'd1;
          end else begin
            scan_c <= scan_c + 1'b1;
          end
          state <= S_SCAN;
        end
        S_PDS: begin
          cd <= drd;
          dir <= DIR_LEFT;
          state <= (drd == '0) ? S_DONE : S_PATH;
        end
        S_PATH: begin
          state <= S_PCMP;
        end
        S_PCMP: begin
          if (step_ok) begin
            out_x <= 3'(hx);
            out_y <= 3'(hy);
            out_valid <= 1'b1;
            out_last <= 1'b0;
            hx <= nx[XW-1:0];
            hy <= ny[YW-1:0];
            cx <= nx[XW-1:0];
            cy <= ny[YW-1:0];
            cd <= cd - 7'd1;
            count <= count + 7'd1;
            dir <= DIR_LEFT;
            if (cd == 7'd1 || count == 7'(MaxResults - 1)) begin
              state <= S_DONE;
            end else begin
              state <= S_PATH;
            end
          end else if (dir == DIR_UP) begin
            state <= S_DONE;
          end else begin
            dir <= dir + 2'd1;
            state <= S_PATH;
          end
        end
        S_DONE: begin
          out_last <= 1'b1;
          out_valid <= have;
          out_x <= have ? 3'(hx) : 3'd0;
          out_y <= have ? 3'(hy) : 3'd0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/gsp_checker.sv -----
// Port-level checks for the grid path search.
// Depends on grid_step_limited_path_search, which it is bound to.
module gsp_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic strobe,
  input logic out_valid,
  input logic out_last
);
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !out_valid |-> out_last) else $error("empty beat not last");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !out_last |-> busy) else $error("beat outside command");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && out_last |-> !busy) else $error("busy after last beat");
  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    strobe && out_last |=> !strobe) else $error("beat right after last beat");
endmodule

bind grid_step_limited_path_search gsp_checker u_chk (
  .clk, .rst, .busy, .strobe, .out_valid, .out_last
);
